/* sv/ilffa_pkg.sv */
// Shared codes and the heap initialization table of the first-fit allocator.
package ilffa_pkg;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_MEMORY = 3'd2,
    ST_FREED     = 3'd3,
    ST_NULL_FREE = 3'd4
  } status_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int unsigned INIT_STEPS    = 6;
  localparam int unsigned INIT_HEAP_END = 16 + 4096;
  localparam logic [16:0] EXTEND_RESET  = 17'd4096;

  // Padding word, prologue header and footer, then one free 4096-byte chunk
  // and the epilogue behind it.
  function automatic logic [12:0] init_addr(logic [2:0] idx);
    logic [12:0] a;
    unique case (idx)
      3'd0:    a = 13'd0;
      3'd1:    a = 13'd4;
      3'd2:    a = 13'd8;
      3'd3:    a = 13'd12;
      3'd4:    a = 13'd4104;
      3'd5:    a = 13'd4108;
      default: a = 13'd0;
    endcase
    return a;
  endfunction

  function automatic logic [12:0] init_value(logic [2:0] idx);
    logic [12:0] v;
    unique case (idx)
      3'd0:    v = 13'd0;
      3'd1:    v = 13'd9;
      3'd2:    v = 13'd9;
      3'd3:    v = 13'd4096;
      3'd4:    v = 13'd4096;
      3'd5:    v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/implicit_list_first_fit_allocator.sv */
// Boundary-tag heap allocator with first-fit search, splitting and coalescing.
//
// Input channel (in_valid_i / in_stall_o) carries one request word: opcode_i
// selects allocate or free, req_size_i is the payload size for allocate and
// block_addr_i the payload offset for free. The output channel
// (out_valid_o / out_stall_i) returns one word per request: result_addr_o
// and status_o. cfg_we_i writes cfg_wdata_i into the minimum heap growth.
// All tags live in one single-port RAM with registered read, and every tag
// access goes through it one at a time: a free reads its own header,
// rewrites header and footer, reads the neighbors' tags and writes a merged
// header and footer when it merges; an allocate reads one header per block
// visited by the first-fit walk, then writes the placed block's tags and,
// when it splits, the remainder's; when no block fits, it first grows the heap.
// A null free or zero-size allocate answers in the cycle after acceptance.
// One request is handled at a time; in_stall_o stays high from acceptance
// until the answer has been taken. After reset the block writes the initial
// heap (prologue, one 4096-byte free chunk, epilogue) with in_stall_o high.
// While the receiver stalls, the answer is held and no new request is taken.
module implicit_list_first_fit_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] block_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_addr_o,
  output logic [2:0]  status_o
);

  localparam int AB    = $clog2(HEAP_BYTES);
  localparam int TW    = AB + 1;
  localparam int OW    = (AB + 2 > 18) ? AB + 2 : 18;
  localparam int DEPTH = HEAP_BYTES / 4;
  localparam int IW    = $clog2(DEPTH);
  localparam logic [OW:0] HEAP_LIM = (OW+1)'(HEAP_BYTES);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_FR_RD, S_FR_WH, S_FR_WF,
    S_MP_RD, S_MP_CALC, S_MPH_RD, S_MPH_CALC, S_MPF_RD, S_MPF_CALC,
    S_MS_RD, S_MS_CALC, S_MN_RD, S_MN_CALC, S_MW1, S_MW2, S_MEND,
    S_AF_RD, S_AF_CHK, S_GW1, S_GW2, S_GW3,
    S_PL_RD, S_PL_CHK, S_PW1, S_PW2, S_PW3, S_PW4
  } state_e;

  state_e             state_q;
  logic [2:0]         init_cnt_q;
  logic [OW-1:0]      bp_q, p_q, n_q, a_q, w2a_q, res_q, heap_end_q;
  logic [TW-1:0]      s_q, ps_q, wv_q;
  logic [16:0]        asize_q, extend_q;
  logic               op_free_q, pa_q, split_q, oor_q;
  logic               out_valid_q;
  logic [15:0]        result_addr_q;
  ilffa_pkg::status_e status_q;

  logic [OW-1:0] mem_addr;
  logic          mem_we;
  logic [TW-1:0] mem_wdata, ram_rdata, rd_val, sz;
  logic [OW-1:0] sz_w;
  logic          al, mem_oor;

  // Tag reads beyond the heap answer zero and writes there are dropped.
  assign mem_oor = ({1'b0, mem_addr} >= HEAP_LIM);
  assign rd_val  = oor_q ? '0 : ram_rdata;
  assign sz      = {rd_val[TW-1:3], 3'b000};
  assign sz_w    = OW'(sz);
  assign al      = rd_val[0];

  ilffa_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tags (
    .clk_i  (clk_i),
    .we_i   (mem_we && !mem_oor),
    .addr_i (mem_addr[IW+1:2]),
    .wdata_i(mem_wdata),
    .rdata_o(ram_rdata)
  );

  // Merge sums, growth size and rounded request size.
  logic [TW-1:0] s_pn, s_pp, s_all;
  logic [16:0]   ext, req_round, asize_new;
  logic [15:0]   wsum;
  logic [17:0]   gbytes;
  logic [OW:0]   heap_sum;

  always_comb begin
    s_pn      = s_q + sz;
    s_pp      = s_q + ps_q;
    s_all     = s_q + ps_q + sz;
    ext       = (asize_q > extend_q) ? asize_q : extend_q;
    wsum      = {1'b0, ext[16:2]} + 16'(ext[2]);
    gbytes    = {wsum, 2'b00};
    heap_sum  = {1'b0, heap_end_q} + (OW+1)'(gbytes);
    req_round = ({1'b0, req_size_i} + 17'd15) & ~17'd7;
    asize_new = (req_size_i <= 16'd8) ? 17'd16 : req_round;
  end

  always_comb begin
    mem_addr  = bp_q - OW'(4);
    mem_we    = 1'b0;
    mem_wdata = wv_q;
    unique case (state_q)
      S_INIT: begin
        mem_addr  = OW'(ilffa_pkg::init_addr(init_cnt_q));
        mem_we    = 1'b1;
        mem_wdata = TW'(ilffa_pkg::init_value(init_cnt_q));
      end
      S_FR_WH: begin
        mem_we    = 1'b1;
        mem_wdata = sz;
      end
      S_FR_WF: begin
        mem_addr  = a_q;
        mem_we    = 1'b1;
        mem_wdata = s_q;
      end
      S_MP_RD:  mem_addr = bp_q - OW'(8);
      S_MPH_RD: mem_addr = p_q - OW'(4);
      S_MPF_RD: mem_addr = a_q;
      S_MN_RD:  mem_addr = n_q - OW'(4);
      S_MW1, S_PW2, S_GW2: begin
        mem_addr = a_q;
        mem_we   = 1'b1;
      end
      S_MW2: begin
        mem_addr = w2a_q;
        mem_we   = 1'b1;
      end
      S_GW1, S_PW1: mem_we = 1'b1;
      S_GW3: begin
        mem_addr  = w2a_q;
        mem_we    = 1'b1;
        mem_wdata = TW'(1);
      end
      S_PW3: begin
        mem_addr  = w2a_q;
        mem_we    = 1'b1;
        mem_wdata = s_q;
      end
      S_PW4: begin
        mem_addr  = n_q;
        mem_we    = 1'b1;
        mem_wdata = s_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_cnt_q  <= '0;
      heap_end_q  <= OW'(ilffa_pkg::INIT_HEAP_END);
      extend_q    <= ilffa_pkg::EXTEND_RESET;
      out_valid_q <= 1'b0;
      oor_q       <= 1'b0;
    end else begin
      oor_q <= mem_oor;
      if (cfg_we_i) begin
        extend_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          init_cnt_q <= init_cnt_q + 3'd1;
          if (init_cnt_q == 3'(ilffa_pkg::INIT_STEPS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            result_addr_q <= '0;
            if (opcode_i == ilffa_pkg::OP_FREE) begin
              if (block_addr_i == 16'd0) begin
                status_q    <= ilffa_pkg::ST_NULL_FREE;
                out_valid_q <= 1'b1;
              end else begin
                bp_q      <= OW'(block_addr_i);
                op_free_q <= 1'b1;
                state_q   <= S_FR_RD;
              end
            end else if (req_size_i == 16'd0) begin
              status_q    <= ilffa_pkg::ST_ZERO_SIZE;
              out_valid_q <= 1'b1;
            end else begin
              asize_q   <= asize_new;
              bp_q      <= OW'(8);
              op_free_q <= 1'b0;
              state_q   <= S_AF_RD;
            end
          end
        end
        S_FR_RD: state_q <= S_FR_WH;
        S_FR_WH: begin
          s_q     <= sz;
          a_q     <= bp_q + sz_w - OW'(8);
          state_q <= S_FR_WF;
        end
        S_FR_WF:  state_q <= S_MP_RD;
        S_MP_RD:  state_q <= S_MP_CALC;
        S_MP_CALC: begin
          p_q     <= bp_q - sz_w;
          state_q <= S_MPH_RD;
        end
        S_MPH_RD: state_q <= S_MPH_CALC;
        S_MPH_CALC: begin
          ps_q    <= sz;
          a_q     <= p_q + sz_w - OW'(8);
          state_q <= S_MPF_RD;
        end
        S_MPF_RD: state_q <= S_MPF_CALC;
        S_MPF_CALC: begin
          pa_q    <= al;
          state_q <= S_MS_RD;
        end
        S_MS_RD: state_q <= S_MS_CALC;
        S_MS_CALC: begin
          s_q     <= sz;
          n_q     <= bp_q + sz_w;
          state_q <= S_MN_RD;
        end
        S_MN_RD: state_q <= S_MN_CALC;
        S_MN_CALC: begin
          // Here the read data is the next block's header.
          if (pa_q && al) begin
            res_q   <= bp_q;
            state_q <= S_MEND;
          end else if (pa_q) begin
            wv_q    <= s_pn;
            a_q     <= bp_q - OW'(4);
            w2a_q   <= bp_q + OW'(s_pn) - OW'(8);
            res_q   <= bp_q;
            state_q <= S_MW1;
          end else if (al) begin
            wv_q    <= s_pp;
            a_q     <= bp_q + OW'(s_q) - OW'(8);
            w2a_q   <= p_q - OW'(4);
            res_q   <= p_q;
            state_q <= S_MW1;
          end else begin
            wv_q    <= s_all;
            a_q     <= p_q - OW'(4);
            // When both neighbors are the same word, the footer follows the
            // freshly written header.
            w2a_q   <= (p_q == n_q) ? n_q + OW'(s_all) - OW'(8)
                                    : n_q + sz_w - OW'(8);
            res_q   <= p_q;
            state_q <= S_MW1;
          end
        end
        S_MW1: state_q <= S_MW2;
        S_MW2: state_q <= S_MEND;
        S_MEND: begin
          if (op_free_q) begin
            status_q    <= ilffa_pkg::ST_FREED;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            bp_q    <= res_q;
            state_q <= S_PL_RD;
          end
        end
        S_AF_RD: state_q <= S_AF_CHK;
        S_AF_CHK: begin
          if (sz == '0) begin
            if (heap_sum > HEAP_LIM) begin
              status_q    <= ilffa_pkg::ST_NO_MEMORY;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              bp_q       <= heap_end_q;
              heap_end_q <= heap_sum[OW-1:0];
              wv_q       <= TW'(gbytes);
              a_q        <= heap_sum[OW-1:0] - OW'(8);
              w2a_q      <= heap_sum[OW-1:0] - OW'(4);
              state_q    <= S_GW1;
            end
          end else if (!al && sz_w >= OW'(asize_q)) begin
            state_q <= S_PL_RD;
          end else begin
            bp_q    <= bp_q + sz_w;
            state_q <= S_AF_RD;
          end
        end
        S_GW1:   state_q <= S_GW2;
        S_GW2:   state_q <= S_GW3;
        S_GW3:   state_q <= S_MP_RD;
        S_PL_RD: state_q <= S_PL_CHK;
        S_PL_CHK: begin
          if (sz_w >= OW'(asize_q) + OW'(16)) begin
            split_q <= 1'b1;
            wv_q    <= TW'(asize_q) | TW'(1);
            a_q     <= bp_q + OW'(asize_q) - OW'(8);
            w2a_q   <= bp_q + OW'(asize_q) - OW'(4);
            s_q     <= sz - TW'(asize_q);
            n_q     <= bp_q + sz_w - OW'(8);
          end else begin
            split_q <= 1'b0;
            wv_q    <= sz | TW'(1);
            a_q     <= bp_q + sz_w - OW'(8);
          end
          state_q <= S_PW1;
        end
        S_PW1: state_q <= S_PW2;
        S_PW2: begin
          if (split_q) begin
            state_q <= S_PW3;
          end else begin
            result_addr_q <= bp_q[15:0];
            status_q      <= ilffa_pkg::ST_ALLOCATED;
            out_valid_q   <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        S_PW3: state_q <= S_PW4;
        S_PW4: begin
          result_addr_q <= bp_q[15:0];
          status_q      <= ilffa_pkg::ST_ALLOCATED;
          out_valid_q   <= 1'b1;
          state_q       <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o   = out_valid_q;
  assign result_addr_o = result_addr_q;
  assign status_o      = status_q;

endmodule

/* sv/ilffa_ram.sv */
// Generic single-port RAM with registered read data.
module ilffa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ilffa_checker.sv */
// Port-level checks for the first-fit allocator and their binding.
module ilffa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [16:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        opcode_i,
  input logic [15:0] req_size_i,
  input logic [15:0] block_addr_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] result_addr_o,
  input logic [2:0]  status_o
);

  // Only one request is in flight: taking a word closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is pending");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled answer dropped or changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= 3'(ilffa_pkg::ST_NULL_FREE)))
    else $error("undefined status code");

  // Only a successful allocation carries an address.
  a_addr_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != 3'(ilffa_pkg::ST_ALLOCATED)) |-> (result_addr_o == 16'd0))
    else $error("address returned without allocation");

  // A zero-size or null request answers in the next cycle.
  a_quick_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && ((opcode_i == ilffa_pkg::OP_FREE && block_addr_i == 16'd0)
      || (opcode_i == ilffa_pkg::OP_ALLOC && req_size_i == 16'd0))) |=> out_valid_o)
    else $error("trivial request not answered at once");

endmodule

bind implicit_list_first_fit_allocator ilffa_checker u_ilffa_checker (.*);
